/* design/pmw_pkg.sv */
// Package with the types, constants and codes shared by the spanning tree weight block.
`default_nettype none

package pmw_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int WEIGHT_BITS  = 16;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = VTX_W + 1;
	localparam int ADDR_W       = 2 * VTX_W;
	localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
	localparam int SUM_W        = 22;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int VC_RESET     = 64;

	// Register byte addresses, decoded on the word address bit.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_EDGE  = 2'd1,
		CMD_SOLVE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e;

	typedef struct packed {
		logic [1:0]             command;
		logic [VTX_W-1:0]       vertex_a;
		logic [VTX_W-1:0]       vertex_b;
		logic [WEIGHT_BITS-1:0] weight;
	} req_t;

	typedef struct packed {
		logic [SUM_W-1:0] total_weight;
		logic             connected;
	} rsp_t;

	// One adjacency matrix entry: a present bit and the edge weight.
	typedef struct packed {
		logic                   present;
		logic [WEIGHT_BITS-1:0] w;
	} ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cnt_clr;
		logic cnt_inc;
		logic mat_clr_wr;
		logic edge_wr_ab;
		logic edge_wr_ba;
		logic latch_in;
		logic solve_init;
		logic scan_rd;
		logic scan_init;
		logic pick_commit;
		logic emit;
		logic emit_ok;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last_clr;
		logic idx_last_scan;
		logic tree_full;
		logic found;
	} sts_t;

endpackage

`default_nettype wire

/* design/pmw_ram.sv */
// Generic single write port, single read port RAM with a registered read.
`default_nettype none

module pmw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/pmw_ctrl.sv */
// Controller state machine that sequences clears, edge loads and the tree search.
`default_nettype none

module pmw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pmw_pkg::cmd_e command,
	input  wire pmw_pkg::sts_t sts,
	output pmw_pkg::ctl_t      ctl,
	output logic               busy,
	output logic               done
);

	typedef enum logic [2:0] {
		S_RST_CLR,
		S_IDLE,
		S_CLR,
		S_EDGE,
		S_INIT,
		S_UPD,
		S_DRAIN,
		S_PICK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_RST_CLR, S_CLR: begin
				ctl.mat_clr_wr = 1'b1;
				ctl.cnt_inc    = 1'b1;
				if (sts.idx_last_clr) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctl.cnt_clr = 1'b1;
				if (start) begin
					ctl.latch_in = 1'b1;
					unique case (command)
						pmw_pkg::CMD_CLEAR: state_d = S_CLR;
						pmw_pkg::CMD_EDGE: begin
							ctl.edge_wr_ab = 1'b1;
							state_d        = S_EDGE;
						end
						pmw_pkg::CMD_SOLVE: begin
							ctl.solve_init = 1'b1;
							state_d        = S_INIT;
						end
						pmw_pkg::CMD_NONE: state_d = S_IDLE;
					endcase
				end
			end
			S_EDGE: begin
				ctl.edge_wr_ba = 1'b1;
				state_d        = S_IDLE;
			end
			S_INIT, S_UPD: begin
				ctl.scan_rd   = 1'b1;
				ctl.scan_init = (state_q == S_INIT);
				if (sts.idx_last_scan) begin
					ctl.cnt_clr = 1'b1;
					state_d     = S_DRAIN;
				end else begin
					ctl.cnt_inc = 1'b1;
				end
			end
			S_DRAIN: state_d = S_PICK;
			S_PICK: begin
				priority if (sts.tree_full) begin
					ctl.emit    = 1'b1;
					ctl.emit_ok = 1'b1;
					state_d     = S_IDLE;
				end else if (!sts.found) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					ctl.pick_commit = 1'b1;
					state_d         = S_UPD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctl.emit;
		end
	end

endmodule

`default_nettype wire

/* design/pmw_dp.sv */
// Datapath with the adjacency matrix, the best link table and the tree search registers.
`default_nettype none

module pmw_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pmw_pkg::ctl_t               ctl,
	output pmw_pkg::sts_t                    sts,
	input  wire pmw_pkg::req_t               req,
	input  wire logic [pmw_pkg::CNT_W-1:0]   vertex_count,
	output pmw_pkg::rsp_t                    rsp
);

	localparam int ENT_W = $bits(pmw_pkg::ent_t);

	logic [pmw_pkg::ADDR_W-1:0]      idx_q;
	logic [pmw_pkg::VTX_W-1:0]       a_q;
	logic [pmw_pkg::VTX_W-1:0]       b_q;
	logic [pmw_pkg::WEIGHT_BITS-1:0] w_q;
	logic [pmw_pkg::CNT_W-1:0]       n_eff;

	logic                            scan_v_s1;
	logic                            init_s1;
	logic [pmw_pkg::VTX_W-1:0]       idx_s1;

	logic [pmw_pkg::MAX_VERTICES-1:0] mask_q;
	logic [pmw_pkg::CNT_W-1:0]        size_q;
	logic [pmw_pkg::SUM_W-1:0]        sum_q;
	logic                             found_q;
	logic [pmw_pkg::VTX_W-1:0]        pick_q;
	logic [pmw_pkg::WEIGHT_BITS-1:0]  minw_q;
	logic [pmw_pkg::VTX_W-1:0]        row_q;
	pmw_pkg::rsp_t                    rsp_q;

	logic                       mat_we;
	logic [pmw_pkg::ADDR_W-1:0] mat_waddr;
	logic [ENT_W-1:0]           mat_wdata;
	logic [ENT_W-1:0]           mat_rdata;
	logic [ENT_W-1:0]           best_rdata;

	pmw_pkg::ent_t e;
	pmw_pkg::ent_t cur;
	pmw_pkg::ent_t nb;
	logic          in_tree;
	logic          upd;
	logic          cand;
	logic [pmw_pkg::SUM_W:0] sum_nx;

	// Vertex counts of zero act as one; counts above the matrix size act as the full size.
	always_comb begin
		priority if (vertex_count == '0) begin
			n_eff = pmw_pkg::CNT_W'(1);
		end else if (vertex_count > pmw_pkg::CNT_W'(pmw_pkg::MAX_VERTICES)) begin
			n_eff = pmw_pkg::CNT_W'(pmw_pkg::MAX_VERTICES);
		end else begin
			n_eff = vertex_count;
		end
	end

	// Matrix write port: clearing sweep, or one of the two halves of an edge.
	always_comb begin
		mat_we    = ctl.mat_clr_wr | ctl.edge_wr_ab | ctl.edge_wr_ba;
		mat_wdata = {1'b1, w_q};
		priority if (ctl.mat_clr_wr) begin
			mat_waddr = idx_q;
			mat_wdata = '0;
		end else if (ctl.edge_wr_ab) begin
			mat_waddr = {req.vertex_a, req.vertex_b};
			mat_wdata = {1'b1, req.weight};
		end else begin
			mat_waddr = {b_q, a_q};
		end
	end

	pmw_ram #(
		.WIDTH (ENT_W),
		.DEPTH (pmw_pkg::MAT_DEPTH)
	) u_mat (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.re    (ctl.scan_rd),
		.raddr ({row_q, idx_q[pmw_pkg::VTX_W-1:0]}),
		.rdata (mat_rdata)
	);

	pmw_ram #(
		.WIDTH (ENT_W),
		.DEPTH (pmw_pkg::MAX_VERTICES)
	) u_best (
		.clk   (clk),
		.we    (scan_v_s1),
		.waddr (idx_s1),
		.wdata (nb),
		.re    (ctl.scan_rd),
		.raddr (idx_q[pmw_pkg::VTX_W-1:0]),
		.rdata (best_rdata)
	);

	// Relax one vertex against the new tree row and fold it into the running minimum.
	always_comb begin
		e       = pmw_pkg::ent_t'(mat_rdata);
		cur     = pmw_pkg::ent_t'(best_rdata);
		in_tree = mask_q[idx_s1];
		upd     = !in_tree && e.present && (!cur.present || (e.w < cur.w));
		nb      = (init_s1 || upd) ? e : cur;
		cand    = !in_tree && nb.present && (!found_q || (nb.w < minw_q));
		sum_nx  = {1'b0, sum_q}
			+ {{(pmw_pkg::SUM_W + 1 - pmw_pkg::WEIGHT_BITS){1'b0}}, minw_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			scan_v_s1 <= 1'b0;
			mask_q    <= '0;
			size_q    <= '0;
			sum_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			if (ctl.cnt_clr) begin
				idx_q <= '0;
			end else if (ctl.cnt_inc) begin
				idx_q <= idx_q + pmw_pkg::ADDR_W'(1);
			end
			scan_v_s1 <= ctl.scan_rd;
			if (ctl.solve_init) begin
				mask_q  <= pmw_pkg::MAX_VERTICES'(1);
				size_q  <= pmw_pkg::CNT_W'(1);
				sum_q   <= '0;
				found_q <= 1'b0;
			end else if (ctl.pick_commit) begin
				mask_q[pick_q] <= 1'b1;
				size_q         <= size_q + pmw_pkg::CNT_W'(1);
				sum_q          <= sum_nx[pmw_pkg::SUM_W] ? '1 : sum_nx[pmw_pkg::SUM_W-1:0];
				found_q        <= 1'b0;
			end else if (scan_v_s1 && cand) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			a_q <= req.vertex_a;
			b_q <= req.vertex_b;
			w_q <= req.weight;
		end
		if (ctl.scan_rd) begin
			idx_s1  <= idx_q[pmw_pkg::VTX_W-1:0];
			init_s1 <= ctl.scan_init;
		end
		if (scan_v_s1 && cand) begin
			pick_q <= idx_s1;
			minw_q <= nb.w;
		end
		if (ctl.solve_init) begin
			row_q <= '0;
		end else if (ctl.pick_commit) begin
			row_q <= pick_q;
		end
		if (ctl.emit) begin
			rsp_q.total_weight <= ctl.emit_ok ? sum_q : '0;
			rsp_q.connected    <= ctl.emit_ok;
		end
	end

	assign sts.idx_last_clr  = (idx_q == '1);
	assign sts.idx_last_scan = ({1'b0, idx_q[pmw_pkg::VTX_W-1:0]}
		== (n_eff - pmw_pkg::CNT_W'(1)));
	assign sts.tree_full     = (size_q >= n_eff);
	assign sts.found         = found_q;
	assign rsp               = rsp_q;

endmodule

`default_nettype wire

/* design/prim_mst_weight.sv */
// Top level of the minimum spanning tree weight block: register port, controller and datapath.
// A clear sweeps every matrix entry, an edge load writes both halves of the edge, and a solve
// scans one matrix row per tree vertex for the n vertices in use (fewer rows on a disconnected graph).
// The result word appears on rsp with done high for one cycle, in the first cycle busy is low.
// Throughput: one command word at a time; a new word is taken once busy falls.
// Reset: asynchronous, active low; afterwards every matrix entry is swept to absent
// with busy high, and vertex_count returns to 64. The result receiver cannot stall.
`default_nettype none

module prim_mst_weight (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire pmw_pkg::req_t                    req,
	output logic                                  done,
	output pmw_pkg::rsp_t                         rsp,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pmw_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [pmw_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [pmw_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                  pready
);

	pmw_pkg::ctl_t             ctl;
	pmw_pkg::sts_t             sts;
	logic [pmw_pkg::CNT_W-1:0] vc_q;
	logic                      reg_hit;

	// The register port never inserts wait states. Byte address bit two selects the register,
	// and only the vertex count register exists; other addresses read as zero.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == pmw_pkg::REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= pmw_pkg::CNT_W'(pmw_pkg::VC_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			vc_q <= pwdata[pmw_pkg::CNT_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(pmw_pkg::CFG_DATA_W - pmw_pkg::CNT_W){1'b0}}, vc_q} : '0;

	// The controller decides what happens each cycle; the datapath holds the matrix,
	// the best link per vertex, the tree mask and the running weight.
	pmw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (pmw_pkg::cmd_e'(req.command)),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	pmw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.req          (req),
		.vertex_count (vc_q),
		.rsp          (rsp)
	);

`ifndef SYNTHESIS
	// A result follows the end of a solve, so the block has just left its busy states.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without a preceding busy solve");

	// A disconnected graph reports a zero total.
	a_disconnected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.connected) |-> (rsp.total_weight == '0))
		else $error("disconnected result carries a nonzero total");

	// Every accepted word other than the unused code keeps the block busy next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.command != pmw_pkg::CMD_NONE)) |=> busy)
		else $error("accepted command word did not make the block busy");

	// Matrix writes never overlap a scan of the matrix.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_rd |-> !(ctl.mat_clr_wr || ctl.edge_wr_ab || ctl.edge_wr_ba || start && !busy))
		else $error("matrix write during a scan");
`endif

endmodule

`default_nettype wire
